>>> rtl/tkpcl_pkg.sv
// ----------------------------------------------------------------------------
// Top-K pair candidate list package
// Shared types, widths and constants of the candidate list block.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpcl_pkg;

    localparam int unsigned DefaultListDepth = 20;
    localparam int unsigned WindowW          = 10;
    localparam int unsigned DistW            = 32;
    localparam int unsigned RankW            = 5;
    localparam int unsigned GapW             = 10;
    localparam logic [GapW-1:0] GapReset     = 10'd5;

    typedef logic [WindowW-1:0] window_t;
    typedef logic [DistW-1:0]   dist_t;
    typedef logic [RankW-1:0]   rank_t;
    typedef logic [GapW-1:0]    gap_t;

    // One offered pair.
    typedef struct packed {
        window_t first_window;
        window_t second_window;
        dist_t   distance;
        logic    last_pair;
    } pair_t;

    // One ranked result.
    typedef struct packed {
        rank_t   rank;
        window_t out_first_window;
        window_t out_second_window;
        dist_t   out_distance;
        logic    last_entry;
    } result_t;

    // One stored list entry.
    typedef struct packed {
        window_t first_window;
        window_t second_window;
        dist_t   distance;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } tkpcl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic emit;
        logic clear;
    } tkpcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic at_last;
    } tkpcl_sts_t;

endpackage

`default_nettype wire

>>> rtl/tkpcl_ctrl.sv
// ----------------------------------------------------------------------------
// Candidate list controller
// Sequences insertion of offered pairs and the ranked readout of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpcl_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire                  last_pair,
    input  tkpcl_pkg::tkpcl_sts_t sts,
    output tkpcl_pkg::tkpcl_cmd_t cmd,
    output logic                 busy
);
    import tkpcl_pkg::*;

    tkpcl_state_t state_reg;
    tkpcl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last_pair)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.empty || sts.at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.insert = start;
            end
            ST_DRAIN:
            begin
                busy      = 1'b1;
                cmd.emit  = !sts.empty;
                cmd.clear = sts.empty || sts.at_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tkpcl_datapath.sv
// ----------------------------------------------------------------------------
// Candidate list datapath
// Sorted entry registers with parallel compare-and-shift insertion and a
// shift-out readout port, plus the gap register and the list counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpcl_datapath #(
    parameter int unsigned LIST_DEPTH = tkpcl_pkg::DefaultListDepth
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tkpcl_pkg::pair_t      pair_in,
    input  wire                   cfg_we,
    input  tkpcl_pkg::gap_t       cfg_wdata,
    input  tkpcl_pkg::tkpcl_cmd_t cmd,
    output tkpcl_pkg::tkpcl_sts_t sts,
    output tkpcl_pkg::result_t    result_out,
    output logic                  result_valid
);
    import tkpcl_pkg::*;

    localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

    entry_t              entry_reg  [LIST_DEPTH];
    entry_t              entry_next [LIST_DEPTH];
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic [CntW-1:0]     rd_reg;
    logic [CntW-1:0]     rd_next;
    gap_t                gap_reg;
    result_t             result_reg;
    logic                result_valid_reg;
    logic [LIST_DEPTH-1:0] lt;
    logic                gap_ok;
    logic                ins;
    logic                inserted;
    entry_t              new_entry;

    assign new_entry.first_window  = pair_in.first_window;
    assign new_entry.second_window = pair_in.second_window;
    assign new_entry.distance      = pair_in.distance;

    assign gap_ok = {1'b0, pair_in.second_window} >=
                    ({1'b0, pair_in.first_window} + {1'b0, gap_reg});
    assign ins    = cmd.insert && gap_ok;

    // Unused slots count as larger than any distance, so lt is a thermometer
    // code that marks the insertion point and every slot behind it.
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            lt[i] = (CntW'(i) >= count_reg) || (pair_in.distance < entry_reg[i].distance);
        end
    end

    assign inserted = ins && lt[LIST_DEPTH-1];

    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_slot
        if (g == 0)
        begin : g_head
            always_comb
            begin
                entry_next[g] = entry_reg[g];
                if (ins && lt[g])
                begin
                    entry_next[g] = new_entry;
                end
                else if (cmd.emit)
                begin
                    if (LIST_DEPTH > 1)
                    begin
                        entry_next[g] = entry_reg[(g + 1) % LIST_DEPTH];
                    end
                end
            end
        end
        else
        begin : g_body
            always_comb
            begin
                entry_next[g] = entry_reg[g];
                if (ins && lt[g])
                begin
                    entry_next[g] = lt[g-1] ? entry_reg[g-1] : new_entry;
                end
                else if (cmd.emit && (g < LIST_DEPTH - 1))
                begin
                    entry_next[g] = entry_reg[(g + 1) % LIST_DEPTH];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        rd_next    = rd_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            rd_next    = '0;
        end
        else
        begin
            if (inserted && (count_reg != CntW'(LIST_DEPTH)))
            begin
                count_next = count_reg + CntW'(1);
            end
            if (cmd.emit)
            begin
                rd_next = rd_reg + CntW'(1);
            end
        end
    end

    assign sts.empty   = (count_reg == '0);
    assign sts.at_last = (rd_reg == (count_reg - CntW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            rd_reg           <= '0;
            gap_reg          <= GapReset;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            rd_reg           <= rd_next;
            result_valid_reg <= cmd.emit;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.rank              <= RankW'(rd_reg);
            result_reg.out_first_window  <= entry_reg[0].first_window;
            result_reg.out_second_window <= entry_reg[0].second_window;
            result_reg.out_distance      <= entry_reg[0].distance;
            result_reg.last_entry        <= sts.at_last;
        end
    end

    assign result_out   = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

>>> rtl/top_k_pair_candidate_list.sv
// ----------------------------------------------------------------------------
// Top-K pair candidate list
// Keeps the LIST_DEPTH best window pairs sorted by ascending distance and
// reads them out in rank order when the final pair of a set arrives.
// ----------------------------------------------------------------------------
// Throughput: for a pair without last_pair busy stays low, and a new pair
//   can be started every cycle (compare-and-shift insert).
// Readout: after a final pair, the state register and then result_valid_reg
//   lie between the accepting edge and the first result; results follow one per
//   cycle, busy is high even for an empty list, and the receiver cannot stall.
// Reset: the list is emptied, gap_reg returns to 5; entries hold junk.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_pair_candidate_list #(
    parameter int unsigned LIST_DEPTH = tkpcl_pkg::DefaultListDepth
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  tkpcl_pkg::pair_t   pair_in,
    input  wire                cfg_we,
    input  tkpcl_pkg::gap_t    cfg_wdata,
    output tkpcl_pkg::result_t result_out,
    output logic               result_valid
);
    import tkpcl_pkg::*;

    tkpcl_cmd_t cmd;
    tkpcl_sts_t sts;

    // The controller decides when a transaction inserts a pair and when the
    // stored list drains; it sees only the handshake and a few status flags.
    tkpcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_pair (pair_in.last_pair),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // The datapath holds the sorted entries. Every slot compares the offered
    // distance against its own entry in parallel, and the resulting
    // thermometer code tells each slot whether to keep, shift or load. The
    // readout shifts the list toward slot zero one entry per cycle.
    tkpcl_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_in      (pair_in),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .result_out   (result_out),
        .result_valid (result_valid)
    );

    // A result is only ever produced by a cycle spent in the readout.
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a preceding readout cycle");

    // An ordinary pair never causes a result.
    a_no_result_on_plain_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !pair_in.last_pair) |=> !result_valid)
        else $error("result produced by a pair that was not final");

    // A final pair always starts the readout.
    a_final_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pair_in.last_pair) |=> busy)
        else $error("final pair did not start the readout");

    // Nothing follows the entry that is marked as the last one.
    a_last_entry_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_out.last_entry) |=> !result_valid)
        else $error("result strobe after the last entry of a readout");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Top-K pair candidate list testbench
// Offers sets of window pairs to the candidate list, keeps its own sorted copy
// of the list, and checks every ranked entry that comes out on a final pair.
// ----------------------------------------------------------------------------

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tkpcl_pkg::*;

    localparam int unsigned Depth = DefaultListDepth;

    // After the last expected entry the block may still be busy with a final
    // pair, so configuration waits SettleCycles more.
    localparam int SettleCycles = 6;

    // Cycles without any transaction before the run is declared hung. The
    // slowest phase idles the sender in 69 percent of cycles, so this leaves a
    // very wide margin.
    localparam int StallLimit = 2000;

    localparam int ReportLimit = 10;

    // One pending transaction for the driver. A pair marked drain_first is
    // held back until every ranked entry predicted so far has been seen.
    typedef struct {
        pair_t pair;
        bit    drain_first;
    } stim_t;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    start       = 1'b0;
    pair_t   pair_in     = '0;
    logic    cfg_we      = 1'b0;
    gap_t    cfg_wdata   = '0;
    logic    busy;
    result_t result_out;
    logic    result_valid;

    // Pairs waiting to be offered, filled by the sequencing block below.
    stim_t   pending_pairs[$];

    // Our own copy of the block: the kept pairs in rank order and the gap.
    entry_t  standings[$];
    gap_t    window_gap = GapReset;

    // Ranked entries that the block still owes us, oldest first.
    result_t owed_ranks[$];

    // ranks_predicted belongs to the driver, ranks_seen to the monitor. The
    // monitor updates its count with a nonblocking assignment, so the driver
    // always reads the value from before the current edge.
    int      ranks_predicted = 0;
    int      ranks_seen      = 0;
    int      sender_idle_pct = 0;
    int      fail_count      = 0;
    int      stall_cycles    = 0;

    top_k_pair_candidate_list #(
        .LIST_DEPTH(Depth)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pair_in     (pair_in),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .result_out  (result_out),
        .result_valid(result_valid)
    );

    always #5 clk = ~clk;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= ReportLimit)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Offer one pair to our copy of the list. A pair whose second window is
    // short of first window plus the gap is dropped, which also drops any
    // reversed pair. On a full list only a strictly better distance than the
    // worst kept one gets in. A new pair goes behind all entries with equal
    // distance, and a full list loses its worst entry. A final pair is
    // handled first; then the whole list is owed in rank order and cleared.
    function automatic void rank_pair(input pair_t p);
        int      slot;
        int      kept;
        entry_t  fresh;
        result_t ranked;

        if (int'(p.second_window) >= int'(p.first_window) + int'(window_gap) &&
            !(standings.size() == Depth &&
              !(p.distance < standings[Depth-1].distance))) begin
            slot = standings.size();
            for (int i = 0; i < standings.size(); i++) begin
                if (p.distance < standings[i].distance) begin
                    slot = i;
                    break;
                end
            end
            fresh.first_window  = p.first_window;
            fresh.second_window = p.second_window;
            fresh.distance      = p.distance;
            standings.insert(slot, fresh);
            if (standings.size() > Depth)
                void'(standings.pop_back());
        end

        if (p.last_pair) begin
            kept = standings.size();
            for (int k = 0; k < kept; k++) begin
                ranked.rank              = rank_t'(k);
                ranked.out_first_window  = standings[k].first_window;
                ranked.out_second_window = standings[k].second_window;
                ranked.out_distance      = standings[k].distance;
                ranked.last_entry        = (k == kept - 1);
                owed_ranks.push_back(ranked);
            end
            ranks_predicted += kept;
            standings.delete();
        end
    endfunction

    // Driver. A pair is taken at an edge where start is high and busy is low.
    // A pair that is not taken stays on the port; otherwise the next pair is
    // put up unless the sender idles this cycle or the pair has to wait for
    // the list readout in flight to drain.
    always @(posedge clk) begin
        bit taken;
        bit offer;

        if (!rst_n) begin
            start   <= 1'b0;
            pair_in <= '0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                rank_pair(pending_pairs[0].pair);
                void'(pending_pairs.pop_front());
            end
            if (start && !taken)
                offer = 1'b1;
            else
                offer = pending_pairs.size() > 0 &&
                        $urandom_range(0, 99) >= sender_idle_pct &&
                        !(pending_pairs[0].drain_first &&
                          ranks_seen != ranks_predicted);
            start <= offer;
            if (offer)
                pair_in <= pending_pairs[0].pair;
        end
    end

    // Monitor. Every strobed entry is compared with the oldest one owed.
    always @(posedge clk) begin
        result_t want;

        if (rst_n && result_valid) begin
            if (owed_ranks.size() == 0) begin
                note_failure($sformatf("unexpected entry rank %0d win %0d-%0d dist %08h",
                                       result_out.rank, result_out.out_first_window,
                                       result_out.out_second_window,
                                       result_out.out_distance));
            end else begin
                want = owed_ranks.pop_front();
                if (result_out.rank !== want.rank ||
                    result_out.out_first_window !== want.out_first_window ||
                    result_out.out_second_window !== want.out_second_window ||
                    result_out.out_distance !== want.out_distance ||
                    result_out.last_entry !== want.last_entry)
                    note_failure($sformatf({"entry mismatch: expected rank %0d win %0d-%0d ",
                                            "dist %08h last %0b, got rank %0d win %0d-%0d ",
                                            "dist %08h last %0b"},
                                           want.rank, want.out_first_window,
                                           want.out_second_window, want.out_distance,
                                           want.last_entry, result_out.rank,
                                           result_out.out_first_window,
                                           result_out.out_second_window,
                                           result_out.out_distance,
                                           result_out.last_entry));
                ranks_seen <= ranks_seen + 1;
            end
        end
    end

    // Watchdog: counts cycles in which no transaction happens on either side.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_pair(input int first, input int second, input logic [31:0] dist_val,
                             input bit last, input bit drain);
        stim_t s;

        s.pair.first_window  = window_t'(first);
        s.pair.second_window = window_t'(second);
        s.pair.distance      = dist_val;
        s.pair.last_pair     = last;
        s.drain_first        = drain;
        pending_pairs.push_back(s);
    endtask

    // One set of pairs closed by a final pair. Most pairs respect the current
    // gap so the list fills up; the rest are fully random and often dropped.
    // Distances often come from a tiny pool so that ties are common.
    task automatic queue_pair_set(input int len, input bit drain);
        int          first;
        int          second;
        logic [31:0] dist_val;

        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 4) != 0) begin
                first  = $urandom_range(0, 1023 - int'(window_gap));
                second = $urandom_range(first + int'(window_gap), 1023);
            end else begin
                first  = $urandom_range(0, 1023);
                second = $urandom_range(0, 1023);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: dist_val = $urandom;
                4, 5, 6, 7: dist_val = $urandom_range(0, 7) << 16;
                8:          dist_val = '0;
                default:    dist_val = '1;
            endcase
            push_pair(first, second, dist_val, j == len - 1, drain && j == 0);
        end
    endtask

    // Wait until nothing is owed, the driver is empty and the block is idle.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || start || ranks_seen != ranks_predicted);
        repeat (SettleCycles) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_gap(input gap_t gap);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= gap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        window_gap = gap;
    endtask

    // A random phase: new gap and sender idling, then whole sets of pairs.
    // Every third set waits for the readout before it to finish.
    task automatic run_phase(input gap_t gap, input int idle_pct, input int n_items);
        int queued;
        int sets;
        int len;

        queued = 0;
        sets   = 0;
        wait_for_quiet();
        write_gap(gap);
        sender_idle_pct = idle_pct;
        while (queued < n_items) begin
            len = $urandom_range(1, 28);
            if (len > n_items - queued)
                len = n_items - queued;
            queue_pair_set(len, sets % 3 == 1);
            queued += len;
            sets++;
        end
    endtask

    initial begin
        logic [31:0] dist_val;
        int          first;
        int          second;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed set at the reset gap of 5. A reversed final pair reads
        // out an empty list, then a pair one window short of the gap.
        push_pair(1023, 0, 32'd0, 1'b1, 1'b0);
        push_pair(0, 4, 32'd1, 1'b0, 1'b0);

        // Twenty accepted pairs fill the list: the exact gap, the widest
        // pair, zero and all-ones distances, and several equal distances.
        for (int i = 0; i < Depth; i++) begin
            if (i == 0) begin
                first  = 0;
                second = 5;
            end else if (i == 1) begin
                first  = 0;
                second = 1023;
            end else if (i == 2) begin
                first  = 1018;
                second = 1023;
            end else begin
                first  = $urandom_range(0, 1018);
                second = $urandom_range(first + 5, 1023);
            end
            if (i == 7)
                dist_val = '1;
            else if (i % 4 == 0)
                dist_val = 32'h0001_0000;
            else if (i % 4 == 1)
                dist_val = $urandom;
            else if (i % 4 == 2)
                dist_val = '0;
            else
                dist_val = 32'h8000_0000 - i;
            push_pair(first, second, dist_val, 1'b0, 1'b0);
        end

        // A tie with the worst entry of the full list is dropped; a final
        // pair tied with the 1.0 entries goes in behind them and pushes the
        // worst entry out before the full readout.
        push_pair(3, 900, '1, 1'b0, 1'b0);
        push_pair(1, 1000, 32'h0001_0000, 1'b1, 1'b0);

        // Random phases over the gap extremes and the sender idling modes.
        run_phase(gap_t'(0), 0, 20);
        run_phase(gap_t'(1023), 69, 10);
        run_phase(gap_t'($urandom_range(0, 40)), 69, 25);
        run_phase(gap_t'($urandom_range(6, 200)), 11, 25);
        run_phase(GapReset, 0, 15);

        wait_for_quiet();
        if (owed_ranks.size() != 0)
            note_failure($sformatf("%0d ranked entries never arrived", owed_ranks.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
